FILE: rtl/b64d_pkg.sv
// Package for the base64 stream decoder: symbol classes, the character
// lookup and the byte assembly from sextets. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    // Class of one input character
    typedef enum logic [1:0] {
        SYM_NONE,
        SYM_DATA,
        SYM_PAD
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t   kind;
        logic [5:0]  value;
    } sym_t;

    localparam int unsigned MAX_BYTES = 3;

    localparam logic [5:0] LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_BASE = 6'd52;
    localparam logic [5:0] PLUS_VALUE = 6'd62;
    localparam logic [5:0] SLASH_VALUE = 6'd63;

    // Map one ASCII character to its sextet, a pad mark or nothing
    function automatic sym_t map_char(input logic [7:0] c);
        sym_t s;
        s.kind  = SYM_NONE;
        s.value = '0;
        case (c) inside
            [8'h41:8'h5A]: begin
                s.kind  = SYM_DATA;
                s.value = 6'(c - 8'h41);
            end
            [8'h61:8'h7A]: begin
                s.kind  = SYM_DATA;
                s.value = 6'(c - 8'h61) + LOWER_BASE;
            end
            [8'h30:8'h39]: begin
                s.kind  = SYM_DATA;
                s.value = 6'(c - 8'h30) + DIGIT_BASE;
            end
            8'h2B: begin
                s.kind  = SYM_DATA;
                s.value = PLUS_VALUE;
            end
            8'h2F: begin
                s.kind  = SYM_DATA;
                s.value = SLASH_VALUE;
            end
            8'h3D: begin
                s.kind  = SYM_PAD;
            end
            default: begin
                s.kind  = SYM_NONE;
            end
        endcase
        return s;
    endfunction

    // First byte: all of s0, top two bits of s1
    function automatic logic [7:0] byte0(input logic [5:0] s0, input logic [5:0] s1);
        return {s0, s1[5:4]};
    endfunction

    // Second byte: low four bits of s1, top four bits of s2
    function automatic logic [7:0] byte1(input logic [5:0] s1, input logic [5:0] s2);
        return {s1[3:0], s2[5:2]};
    endfunction

    // Third byte: low two bits of s2, all of s3
    function automatic logic [7:0] byte2(input logic [5:0] s2, input logic [5:0] s3);
        return {s2[1:0], s3};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/base64_stream_decoder.sv
// Streaming base64 decoder top level: character in, decoded bytes out.
// Depends on b64d_pkg for the character lookup and byte assembly.
//
// A character's bytes pass through the pending stage and then the output
// stage before they are offered. Throughput: one character per cycle; a
// completed group holds the output stage while its three bytes are sent,
// one byte per cycle while m_tready is high, and the input stalls only
// while both stages are occupied. Reset (aresetn low, synchronous) clears
// the group count, finished flag and both stage valid flags.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // character channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic        s_tlast,   // end_of_message
    // byte channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data_byte
    output logic             m_tlast    // last_of_run
);

    localparam int unsigned NB = b64d_pkg::MAX_BYTES;

    // decoder state
    logic [1:0]  grp_cnt_reg, grp_cnt_next;
    logic [5:0]  sext_reg [3];
    logic [5:0]  sext_next [3];
    logic        fin_reg, fin_next;

    // pending stage: bytes of one request waiting for the output register
    logic        pend_valid_reg;
    logic [7:0]  pend_bytes_reg [NB];
    logic [1:0]  pend_cnt_reg;

    // output stage: bytes being sent, one per cycle while m_tready is high
    logic        out_valid_reg;
    logic [7:0]  out_bytes_reg [NB];
    logic [1:0]  out_cnt_reg;
    logic [1:0]  out_idx_reg;

    logic              in_acc;
    logic              out_last;
    logic              out_done;
    logic              out_free;
    b64d_pkg::sym_t    sym;
    logic [7:0]        res_bytes [NB];
    logic [1:0]        res_cnt;

    // pending stage can take a new request when empty or moving on this cycle
    assign s_tready = !pend_valid_reg || out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign sym      = b64d_pkg::map_char(s_tdata);

    // decode one character against the held group
    always_comb begin
        grp_cnt_next = grp_cnt_reg;
        sext_next    = sext_reg;
        fin_next     = fin_reg;
        res_cnt      = 2'd0;
        for (int i = 0; i < NB; i++) begin
            res_bytes[i] = '0;
        end
        if (!fin_reg) begin
            if (sym.kind == b64d_pkg::SYM_PAD) begin
                if (grp_cnt_reg >= 2'd2) begin
                    res_bytes[0] = b64d_pkg::byte0(sext_reg[0], sext_reg[1]);
                    res_cnt      = 2'd1;
                end
                if (grp_cnt_reg == 2'd3) begin
                    res_bytes[1] = b64d_pkg::byte1(sext_reg[1], sext_reg[2]);
                    res_cnt      = 2'd2;
                end
                grp_cnt_next = 2'd0;
                fin_next     = 1'b1;
            end else if (sym.kind == b64d_pkg::SYM_DATA) begin
                if (grp_cnt_reg != 2'd3) begin
                    sext_next[grp_cnt_reg] = sym.value;
                    grp_cnt_next           = grp_cnt_reg + 2'd1;
                end else begin
                    res_bytes[0] = b64d_pkg::byte0(sext_reg[0], sext_reg[1]);
                    res_bytes[1] = b64d_pkg::byte1(sext_reg[1], sext_reg[2]);
                    res_bytes[2] = b64d_pkg::byte2(sext_reg[2], sym.value);
                    res_cnt      = 2'd3;
                    grp_cnt_next = 2'd0;
                end
            end
        end
        // end of message drops any partial group and clears the finished flag
        if (s_tlast) begin
            grp_cnt_next = 2'd0;
            fin_next     = 1'b0;
        end
    end

    // decoder state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_cnt_reg <= 2'd0;
            fin_reg     <= 1'b0;
        end else if (in_acc) begin
            grp_cnt_reg <= grp_cnt_next;
            fin_reg     <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            sext_reg <= sext_next;
        end
    end

    // output stage handshake
    assign out_last = (out_idx_reg == out_cnt_reg - 2'd1);
    assign out_done = out_valid_reg && m_tready && out_last;
    assign out_free = !out_valid_reg || out_done;

    // pending stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (in_acc) begin
            pend_valid_reg <= (res_cnt != 2'd0);
        end else if (out_free) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            pend_bytes_reg <= res_bytes;
            pend_cnt_reg   <= res_cnt;
        end
    end

    // output stage: load from pending, step through the bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= 2'd0;
        end else if (out_free) begin
            out_valid_reg <= pend_valid_reg;
            out_idx_reg   <= 2'd0;
        end else if (m_tready) begin
            out_idx_reg   <= out_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && pend_valid_reg) begin
            out_bytes_reg <= pend_bytes_reg;
            out_cnt_reg   <= pend_cnt_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_bytes_reg[out_idx_reg];
    assign m_tlast  = out_last;

    // checks
    a_out_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_cnt_reg != 2'd0) && (out_idx_reg < out_cnt_reg))
        else $error("output stage index outside its byte count");

    a_pend_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (pend_cnt_reg != 2'd0))
        else $error("pending stage holds an empty request");

    a_fin_grp: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |-> (grp_cnt_reg == 2'd0))
        else $error("group not empty after pad");

    a_pend_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && out_free) |=> out_valid_reg)
        else $error("pending bytes lost on transfer to output");

endmodule

`default_nettype wire
